// ----- rtl/core/thick_stroke_rasterizer_unit_assert.svh -----
// Assertion macros shared by the thick stroke rasterizer RTL.
// Each macro expects signals named clk and arst_n in the module that uses it.
`ifndef THICK_STROKE_RASTERIZER_UNIT_ASSERT_SVH
`define THICK_STROKE_RASTERIZER_UNIT_ASSERT_SVH

// Same-cycle implication, disabled while reset is applied.
`define TSR_ASSERT_IMP(name, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is applied.
`define TSR_ASSERT_NXT(name, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- rtl/core/tsr_pkg.sv -----
// Shared constants, operation codes and types of the thick stroke rasterizer.
// No dependencies; used by tsr_seg_setup and thick_stroke_rasterizer_unit.
package tsr_pkg;

	localparam int MAX_WIDTH_DEF  = 256;
	localparam int MAX_HEIGHT_DEF = 256;
	localparam int FRAC_BITS      = 4;

	localparam int DIM_W   = 13;
	localparam int COORD_W = 17;
	localparam int STEP_W  = 14;
	localparam int LEN_W   = 18;
	localparam int RAD_W   = 10;

	localparam logic [FRAC_BITS-1:0] HALF_PAT = FRAC_BITS'(1 << (FRAC_BITS - 1));

	localparam logic [1:0] OP_STAMP = 2'd0;
	localparam logic [1:0] OP_READ  = 2'd1;
	localparam logic [1:0] OP_CLEAR = 2'd2;

	localparam logic REG_IMAGE_WIDTH  = 1'b0;
	localparam logic REG_IMAGE_HEIGHT = 1'b1;

	typedef struct packed {
		logic [STEP_W-1:0]         steps;
		logic signed [COORD_W-1:0] qx;
		logic [STEP_W-1:0]         rx;
		logic signed [COORD_W-1:0] qy;
		logic [STEP_W-1:0]         ry;
	} seg_plan_t;

endpackage

// ----- rtl/core/thick_stroke_rasterizer_unit.sv -----
// Thick stroke rasterizer top level: one-bit bitmap in a row-wide memory,
// disc stamping by read-modify-write of whole rows. Depends on tsr_pkg,
// tsr_seg_setup and thick_stroke_rasterizer_unit_assert.svh.
//
// Usage: one transaction on the input channel (in_valid/in_ready) carries an
// operation: stamp a segment, read a pixel or clear the bitmap. Every input
// transaction gives exactly one output transaction (out_valid/out_ready) with
// pixel_value and out_of_bounds; both are zero except for a read. The
// configuration channel (cfg_valid/cfg_ready) sets the active image size and
// is always ready.
// Operation: an in-range read fetches the row that holds the pixel. A clear
// zeroes one memory row per cycle. A stamp first runs setup (one square root
// and three divisions, one bit per cycle in a shared unit), then for each
// disc reads each bounding-box row once, paints it one pixel per cycle and
// writes it back through the memory's single write port.
// After reset the block sweeps every memory row to zero and accepts
// no transaction until the sweep ends. A new transaction is taken as soon as
// the previous one has finished; a stalled receiver holds the result in the
// output register and blocks only the completion of the next transaction.
module thick_stroke_rasterizer_unit #(
	parameter int MAX_WIDTH  = tsr_pkg::MAX_WIDTH_DEF,
	parameter int MAX_HEIGHT = tsr_pkg::MAX_HEIGHT_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic        cfg_index,
	input  logic [8:0]  cfg_data,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [1:0]  op,
	input  logic signed [15:0] start_x,
	input  logic signed [15:0] start_y,
	input  logic signed [15:0] end_x,
	input  logic signed [15:0] end_y,
	input  logic [9:0]  radius,
	input  logic [7:0]  pixel_x,
	input  logic [7:0]  pixel_y,
	output logic        out_valid,
	input  logic        out_ready,
	output logic        pixel_value,
	output logic        out_of_bounds
);

	`include "thick_stroke_rasterizer_unit_assert.svh"

	localparam int XW = $clog2(MAX_WIDTH);
	localparam int YW = $clog2(MAX_HEIGHT);
	localparam int FB = tsr_pkg::FRAC_BITS;
	localparam int CW = tsr_pkg::COORD_W;
	localparam int SW = tsr_pkg::STEP_W;
	localparam int DW = tsr_pkg::DIM_W;

	localparam logic [3:0] ST_CLR   = 4'd0;
	localparam logic [3:0] ST_IDLE  = 4'd1;
	localparam logic [3:0] ST_SETUP = 4'd2;
	localparam logic [3:0] ST_BOX   = 4'd3;
	localparam logic [3:0] ST_ROW   = 4'd4;
	localparam logic [3:0] ST_PIX   = 4'd5;
	localparam logic [3:0] ST_WB    = 4'd6;
	localparam logic [3:0] ST_ADV   = 4'd7;
	localparam logic [3:0] ST_RD    = 4'd8;
	localparam logic [3:0] ST_RDD   = 4'd9;
	localparam logic [3:0] ST_FIN   = 4'd10;

	logic [3:0]    state_q;
	logic [YW-1:0] clr_row_q;
	logic          clr_user_q;
	logic [8:0]    wreg_q, hreg_q;
	logic          seg_start_q;
	logic          out_valid_q;
	logic          pixel_value_q, oob_q;

	logic signed [15:0]   x0_q, y0_q;
	logic signed [CW-1:0] dx_q, dy_q;
	logic [9:0]           r_q;
	logic [19:0]          r2_q;
	logic [7:0]           px_q, py_q;
	logic                 res_val_q, res_oob_q;
	tsr_pkg::seg_plan_t   plan_q;
	logic [SW-1:0]        i_q, remx_q, remy_q;
	logic signed [CW-1:0] qx_q, qy_q, cx_q, cy_q;
	logic [XW-1:0]        xl_q, xh_q, x_q;
	logic [YW-1:0]        y_q, yh_q;
	logic [23:0]          ey2_q;
	logic [MAX_WIDTH-1:0] mask_q;

	logic [MAX_WIDTH-1:0] bitmap_mem [MAX_HEIGHT];
	logic [MAX_WIDTH-1:0] mem_rdata_q;
	logic                 mem_we, mem_re;
	logic [YW-1:0]        mem_wa, mem_ra;
	logic [MAX_WIDTH-1:0] mem_wd;

	logic                 seg_done;
	tsr_pkg::seg_plan_t   seg_plan;

	logic [DW-1:0] act_w, act_h, wm1, hm1;
	logic          in_acc, rd_oob, out_slot;
	logic signed [17:0] sx_lo, sx_hi, sy_lo, sy_hi;
	logic signed [17:0] bxl, bxh, byl, byh, xl_c, xh_c, yl_c, yh_c;
	logic          box_empty;
	logic signed [18:0] ex_full, ey_full;
	logic signed [11:0] ex, ey;
	logic [23:0]   ex2, ey2;
	logic          hit;
	logic [SW:0]   sumx, sumy;
	logic          cyx, cyy;
	logic [SW-1:0] nremx, nremy;
	logic signed [CW-1:0] nqx, nqy;

	tsr_seg_setup u_setup (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (seg_start_q),
		.dx     (dx_q),
		.dy     (dy_q),
		.step   (r_q),
		.done   (seg_done),
		.plan   (seg_plan)
	);

	always_comb begin
		if (wreg_q == '0) begin
			act_w = DW'(1);
		end else if (DW'(wreg_q) > DW'(MAX_WIDTH)) begin
			act_w = DW'(MAX_WIDTH);
		end else begin
			act_w = DW'(wreg_q);
		end
		if (hreg_q == '0) begin
			act_h = DW'(1);
		end else if (DW'(hreg_q) > DW'(MAX_HEIGHT)) begin
			act_h = DW'(MAX_HEIGHT);
		end else begin
			act_h = DW'(hreg_q);
		end
	end

	assign wm1      = act_w - DW'(1);
	assign hm1      = act_h - DW'(1);
	assign in_ready = (state_q == ST_IDLE);
	assign in_acc   = in_valid && in_ready;
	assign rd_oob   = (DW'(pixel_x) >= act_w) || (DW'(pixel_y) >= act_h);
	assign out_slot = !out_valid_q || out_ready;
	assign cfg_ready = 1'b1;

	// Disc bounding box in pixel units, clipped to the active image.
	assign sx_lo = $signed(18'(cx_q)) - $signed(18'(r_q));
	assign sx_hi = $signed(18'(cx_q)) + $signed(18'(r_q));
	assign sy_lo = $signed(18'(cy_q)) - $signed(18'(r_q));
	assign sy_hi = $signed(18'(cy_q)) + $signed(18'(r_q));
	assign bxl   = sx_lo >>> FB;
	assign bxh   = (sx_hi >>> FB) + 18'sd1;
	assign byl   = sy_lo >>> FB;
	assign byh   = (sy_hi >>> FB) + 18'sd1;
	assign xl_c  = (bxl < 18'sd0) ? 18'sd0 : bxl;
	assign yl_c  = (byl < 18'sd0) ? 18'sd0 : byl;
	assign xh_c  = (bxh > $signed(18'(wm1))) ? $signed(18'(wm1)) : bxh;
	assign yh_c  = (byh > $signed(18'(hm1))) ? $signed(18'(hm1)) : byh;
	assign box_empty = (xl_c > xh_c) || (yl_c > yh_c);

	assign ex_full = $signed(19'({x_q, tsr_pkg::HALF_PAT})) - $signed(19'(cx_q));
	assign ey_full = $signed(19'({y_q, tsr_pkg::HALF_PAT})) - $signed(19'(cy_q));
	assign ex      = ex_full[11:0];
	assign ey      = ey_full[11:0];
	assign ex2     = ex * ex;
	assign ey2     = ey * ey;
	assign hit     = (ex2 + ey2_q) <= 24'(r2_q);

	assign sumx  = {1'b0, remx_q} + {1'b0, plan_q.rx};
	assign sumy  = {1'b0, remy_q} + {1'b0, plan_q.ry};
	assign cyx   = sumx >= {1'b0, plan_q.steps};
	assign cyy   = sumy >= {1'b0, plan_q.steps};
	assign nremx = cyx ? SW'(sumx - {1'b0, plan_q.steps}) : sumx[SW-1:0];
	assign nremy = cyy ? SW'(sumy - {1'b0, plan_q.steps}) : sumy[SW-1:0];
	assign nqx   = qx_q + plan_q.qx + $signed(CW'(cyx));
	assign nqy   = qy_q + plan_q.qy + $signed(CW'(cyy));

	assign mem_we = (state_q == ST_CLR) || (state_q == ST_WB);
	assign mem_wa = (state_q == ST_CLR) ? clr_row_q : y_q;
	assign mem_wd = (state_q == ST_CLR) ? '0 : (mem_rdata_q | mask_q);
	assign mem_re = (state_q == ST_ROW) || (state_q == ST_RD);
	assign mem_ra = (state_q == ST_ROW) ? y_q : YW'(py_q);

	always_ff @(posedge clk) begin
		if (mem_we) begin
			bitmap_mem[mem_wa] <= mem_wd;
		end
		if (mem_re) begin
			mem_rdata_q <= bitmap_mem[mem_ra];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_CLR;
			clr_row_q     <= '0;
			clr_user_q    <= 1'b0;
			wreg_q        <= 9'd256;
			hreg_q        <= 9'd256;
			seg_start_q   <= 1'b0;
			out_valid_q   <= 1'b0;
			pixel_value_q <= 1'b0;
			oob_q         <= 1'b0;
		end else begin
			seg_start_q <= 1'b0;
			if (cfg_valid && cfg_ready) begin
				if (cfg_index == tsr_pkg::REG_IMAGE_WIDTH) begin
					wreg_q <= cfg_data;
				end else begin
					hreg_q <= cfg_data;
				end
			end
			if (state_q == ST_FIN && out_slot) begin
				out_valid_q   <= 1'b1;
				pixel_value_q <= res_val_q;
				oob_q         <= res_oob_q;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_CLR: begin
					if (clr_row_q == YW'(MAX_HEIGHT - 1)) begin
						state_q <= clr_user_q ? ST_FIN : ST_IDLE;
					end else begin
						clr_row_q <= clr_row_q + YW'(1);
					end
				end
				ST_IDLE: begin
					if (in_acc) begin
						case (op)
							tsr_pkg::OP_STAMP: begin
								seg_start_q <= 1'b1;
								state_q     <= ST_SETUP;
							end
							tsr_pkg::OP_READ: begin
								state_q <= rd_oob ? ST_FIN : ST_RD;
							end
							tsr_pkg::OP_CLEAR: begin
								clr_row_q  <= '0;
								clr_user_q <= 1'b1;
								state_q    <= ST_CLR;
							end
							default: begin
								state_q <= ST_FIN;
							end
						endcase
					end
				end
				ST_SETUP: begin
					if (seg_done) begin
						state_q <= ST_BOX;
					end
				end
				ST_BOX: begin
					state_q <= box_empty ? ST_ADV : ST_ROW;
				end
				ST_ROW: begin
					state_q <= ST_PIX;
				end
				ST_PIX: begin
					if (x_q == xh_q) begin
						state_q <= ST_WB;
					end
				end
				ST_WB: begin
					state_q <= (y_q == yh_q) ? ST_ADV : ST_ROW;
				end
				ST_ADV: begin
					state_q <= (i_q == plan_q.steps) ? ST_FIN : ST_BOX;
				end
				ST_RD: begin
					state_q <= ST_RDD;
				end
				ST_RDD: begin
					state_q <= ST_FIN;
				end
				ST_FIN: begin
					if (out_slot) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				x0_q      <= start_x;
				y0_q      <= start_y;
				dx_q      <= CW'(end_x) - CW'(start_x);
				dy_q      <= CW'(end_y) - CW'(start_y);
				r_q       <= radius;
				r2_q      <= radius * radius;
				px_q      <= pixel_x;
				py_q      <= pixel_y;
				res_val_q <= 1'b0;
				res_oob_q <= (op == tsr_pkg::OP_READ) && rd_oob;
			end
			ST_SETUP: begin
				plan_q <= seg_plan;
				i_q    <= '0;
				qx_q   <= '0;
				qy_q   <= '0;
				remx_q <= '0;
				remy_q <= '0;
				cx_q   <= CW'(x0_q);
				cy_q   <= CW'(y0_q);
			end
			ST_BOX: begin
				xl_q <= xl_c[XW-1:0];
				xh_q <= xh_c[XW-1:0];
				y_q  <= yl_c[YW-1:0];
				yh_q <= yh_c[YW-1:0];
			end
			ST_ROW: begin
				ey2_q  <= ey2;
				x_q    <= xl_q;
				mask_q <= '0;
			end
			ST_PIX: begin
				if (hit) begin
					mask_q[x_q] <= 1'b1;
				end
				x_q <= x_q + XW'(1);
			end
			ST_WB: begin
				y_q <= y_q + YW'(1);
			end
			ST_ADV: begin
				i_q    <= i_q + SW'(1);
				qx_q   <= nqx;
				qy_q   <= nqy;
				remx_q <= nremx;
				remy_q <= nremy;
				cx_q   <= CW'(x0_q) + nqx;
				cy_q   <= CW'(y0_q) + nqy;
			end
			ST_RDD: begin
				res_val_q <= mem_rdata_q[XW'(px_q)];
			end
			default: begin
			end
		endcase
	end

	assign out_valid     = out_valid_q;
	assign pixel_value   = pixel_value_q;
	assign out_of_bounds = oob_q;

	`TSR_ASSERT_IMP(a_no_row_clash, mem_we && mem_re, mem_wa != mem_ra, "Row read and write collide.")
	`TSR_ASSERT_IMP(a_pix_in_box, state_q == ST_PIX, x_q <= xh_q, "Pixel walk left its box.")
	`TSR_ASSERT_IMP(a_setup_owned, seg_done, state_q == ST_SETUP, "Setup finished unexpectedly.")
	`TSR_ASSERT_IMP(a_rem_bound, (state_q == ST_BOX) && (plan_q.steps != '0),
		(remx_q < plan_q.steps) && (remy_q < plan_q.steps), "Step remainder out of range.")
	`TSR_ASSERT_NXT(a_fin_delivers, (state_q == ST_FIN) && out_slot,
		(state_q == ST_IDLE) && out_valid_q, "Finished transaction not presented.")

endmodule

// ----- rtl/core/tsr_seg_setup.sv -----
// Segment setup: length by an iterative square root, step count and per-step
// increments by a shared restoring divider. Depends on tsr_pkg.
module tsr_seg_setup (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               start,
	input  logic signed [tsr_pkg::COORD_W-1:0] dx,
	input  logic signed [tsr_pkg::COORD_W-1:0] dy,
	input  logic [tsr_pkg::RAD_W-1:0]          step,
	output logic                               done,
	output tsr_pkg::seg_plan_t                 plan
);

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_SQ   = 3'd1;
	localparam logic [2:0] ST_SUM  = 3'd2;
	localparam logic [2:0] ST_SQRT = 3'd3;
	localparam logic [2:0] ST_LEN  = 3'd4;
	localparam logic [2:0] ST_DLD  = 3'd5;
	localparam logic [2:0] ST_DIV  = 3'd6;
	localparam logic [2:0] ST_DEND = 3'd7;

	logic [2:0]  state_q;
	logic [4:0]  cnt_q;
	logic [1:0]  sel_q;
	logic        done_q;
	logic [15:0] adx_q, ady_q;
	logic        negx_q, negy_q;
	logic [tsr_pkg::RAD_W-1:0] step_q;
	logic [31:0] a2_q, b2_q;
	logic [35:0] n_q, bit_q;
	logic [36:0] res_q;
	logic [tsr_pkg::LEN_W-1:0] len_q;
	logic [tsr_pkg::LEN_W-1:0] quo_q;
	logic [tsr_pkg::STEP_W-1:0] rem_q, dvs_q;
	tsr_pkg::seg_plan_t plan_q;

	logic [16:0] ndx, ndy;
	logic [36:0] sqrt_sum;
	logic [14:0] trial, diff;
	logic        ge;
	logic        fneg;
	logic [15:0] qa;
	logic signed [tsr_pkg::COORD_W-1:0] fq;
	logic [tsr_pkg::STEP_W-1:0] fr;

	assign ndx      = -dx;
	assign ndy      = -dy;
	assign sqrt_sum = res_q + {1'b0, bit_q};
	assign trial    = {rem_q, quo_q[tsr_pkg::LEN_W-1]};
	assign ge       = trial >= {1'b0, dvs_q};
	assign diff     = trial - {1'b0, dvs_q};
	assign qa       = quo_q[15:0];
	assign fneg     = (sel_q == 2'd1) ? negx_q : negy_q;

	always_comb begin
		if (!fneg) begin
			fq = $signed({1'b0, qa});
			fr = rem_q;
		end else if (rem_q == '0) begin
			fq = -$signed({1'b0, qa});
			fr = '0;
		end else begin
			fq = $signed(~{1'b0, qa});
			fr = plan_q.steps - rem_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
			sel_q   <= '0;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (start) begin
						state_q <= ST_SQ;
					end
				end
				ST_SQ: begin
					state_q <= ST_SUM;
				end
				ST_SUM: begin
					cnt_q   <= 5'd17;
					state_q <= ST_SQRT;
				end
				ST_SQRT: begin
					cnt_q <= cnt_q - 5'd1;
					if (cnt_q == '0) begin
						state_q <= ST_LEN;
					end
				end
				ST_LEN: begin
					sel_q   <= 2'd0;
					state_q <= ST_DLD;
				end
				ST_DLD: begin
					cnt_q   <= 5'd17;
					state_q <= ST_DIV;
				end
				ST_DIV: begin
					cnt_q <= cnt_q - 5'd1;
					if (cnt_q == '0) begin
						state_q <= ST_DEND;
					end
				end
				ST_DEND: begin
					if (sel_q == 2'd2) begin
						done_q  <= 1'b1;
						state_q <= ST_IDLE;
					end else begin
						sel_q   <= sel_q + 2'd1;
						state_q <= ST_DLD;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				adx_q  <= dx[16] ? ndx[15:0] : dx[15:0];
				ady_q  <= dy[16] ? ndy[15:0] : dy[15:0];
				negx_q <= dx[16];
				negy_q <= dy[16];
				step_q <= (step > tsr_pkg::RAD_W'(1 << tsr_pkg::FRAC_BITS)) ? step :
					tsr_pkg::RAD_W'(1 << tsr_pkg::FRAC_BITS);
			end
			ST_SQ: begin
				a2_q <= adx_q * adx_q;
				b2_q <= ady_q * ady_q;
			end
			ST_SUM: begin
				n_q   <= 36'({33'(a2_q) + 33'(b2_q), 2'b00});
				res_q <= '0;
				bit_q <= 36'(1) << 34;
			end
			ST_SQRT: begin
				if ({1'b0, n_q} >= sqrt_sum) begin
					n_q   <= n_q - sqrt_sum[35:0];
					res_q <= (res_q >> 1) + {1'b0, bit_q};
				end else begin
					res_q <= res_q >> 1;
				end
				bit_q <= bit_q >> 2;
			end
			ST_LEN: begin
				len_q <= res_q[tsr_pkg::LEN_W-1:0] + tsr_pkg::LEN_W'(n_q != '0);
			end
			ST_DLD: begin
				rem_q <= '0;
				case (sel_q)
					2'd0: begin
						quo_q <= len_q + tsr_pkg::LEN_W'(step_q) - tsr_pkg::LEN_W'(1);
						dvs_q <= tsr_pkg::STEP_W'(step_q);
					end
					2'd1: begin
						quo_q <= tsr_pkg::LEN_W'(adx_q);
						dvs_q <= plan_q.steps;
					end
					default: begin
						quo_q <= tsr_pkg::LEN_W'(ady_q);
						dvs_q <= plan_q.steps;
					end
				endcase
			end
			ST_DIV: begin
				rem_q <= ge ? diff[tsr_pkg::STEP_W-1:0] : trial[tsr_pkg::STEP_W-1:0];
				quo_q <= {quo_q[tsr_pkg::LEN_W-2:0], ge};
			end
			ST_DEND: begin
				case (sel_q)
					2'd0: begin
						plan_q.steps <= quo_q[tsr_pkg::STEP_W-1:0];
					end
					2'd1: begin
						plan_q.qx <= fq;
						plan_q.rx <= fr;
					end
					default: begin
						plan_q.qy <= fq;
						plan_q.ry <= fr;
					end
				endcase
			end
			default: begin
			end
		endcase
	end

	assign done = done_q;
	assign plan = plan_q;

endmodule

// ----- test/tb_top.sv -----
// Self-checking testbench for thick_stroke_rasterizer_unit: stamps, reads,
// clears and size changes checked against an in-bench bitmap predictor.
// Depends on tsr_pkg and the rasterizer RTL.
module tb_top;

	localparam logic [1:0] OP_UNUSED = 2'd3;
	localparam int IMG_PITCH = 256;
	localparam int STALL_LIMIT = 250000;

	typedef struct {
		logic [1:0]         op;
		logic signed [15:0] sx, sy, ex, ey;
		logic [9:0]         rad;
		logic [7:0]         px, py;
	} stroke_req_t;

	typedef struct {
		logic value;
		logic oob;
	} pixel_reply_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic cfg_index = tsr_pkg::REG_IMAGE_WIDTH;
	logic [8:0] cfg_data = '0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic [1:0] op = tsr_pkg::OP_READ;
	logic signed [15:0] start_x = '0, start_y = '0, end_x = '0, end_y = '0;
	logic [9:0] radius = '0;
	logic [7:0] pixel_x = '0, pixel_y = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic pixel_value, out_of_bounds;

	bit bmp [0:65535];
	int unsigned width_reg = 256, height_reg = 256;
	pixel_reply_t pixel_replies[$];
	int mismatch_count = 0;
	int hold_len = 0;
	int burst_left = 0;
	int rx_mode = 0, rx_cyc = 0;
	int idle_cycles = 0;
	int last_x = 0, last_y = 0;

	always #2 clk = ~clk;

	thick_stroke_rasterizer_unit DUT (
		.clk(clk), .arst_n(arst_n),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_valid(in_valid), .in_ready(in_ready), .op(op),
		.start_x(start_x), .start_y(start_y), .end_x(end_x), .end_y(end_y),
		.radius(radius), .pixel_x(pixel_x), .pixel_y(pixel_y),
		.out_valid(out_valid), .out_ready(out_ready),
		.pixel_value(pixel_value), .out_of_bounds(out_of_bounds)
	);

	function automatic longint eff_w();
		if (width_reg < 1) return 1;
		if (width_reg > 256) return 256;
		return width_reg;
	endfunction

	function automatic longint eff_h();
		if (height_reg < 1) return 1;
		if (height_reg > 256) return 256;
		return height_reg;
	endfunction

	function automatic longint fdiv(longint a, longint b);
		longint q;
		q = a / b;
		if ((a % b) != 0 && a < 0)
			q--;
		return q;
	endfunction

	function automatic longint ceil_root(longint v);
		longint lo, hi, mid;
		lo = 0;
		hi = 1 << 20;
		while (lo < hi) begin
			mid = (lo + hi) / 2;
			if (mid * mid >= v)
				hi = mid;
			else
				lo = mid + 1;
		end
		return lo;
	endfunction

	function automatic void paint_disc(longint cx, longint cy, longint r);
		longint xl, xh, yl, yh, ex, ey;
		xl = fdiv(cx - r, 16);
		xh = fdiv(cx + r, 16) + 1;
		yl = fdiv(cy - r, 16);
		yh = fdiv(cy + r, 16) + 1;
		if (xl < 0) xl = 0;
		if (yl < 0) yl = 0;
		if (xh > eff_w() - 1) xh = eff_w() - 1;
		if (yh > eff_h() - 1) yh = eff_h() - 1;
		for (longint y = yl; y <= yh; y++) begin
			ey = y * 16 + 8 - cy;
			for (longint x = xl; x <= xh; x++) begin
				ex = x * 16 + 8 - cx;
				if (ex * ex + ey * ey <= r * r)
					bmp[y * IMG_PITCH + x] = 1'b1;
			end
		end
	endfunction

	function automatic void paint_segment(stroke_req_t q);
		longint x0, y0, dx, dy, r, stride, len, steps;
		x0 = q.sx;
		y0 = q.sy;
		dx = longint'(q.ex) - x0;
		dy = longint'(q.ey) - y0;
		r = q.rad;
		if (dx == 0 && dy == 0) begin
			paint_disc(x0, y0, r);
			return;
		end
		stride = (r > 16) ? r : 16;
		len = ceil_root(4 * (dx * dx + dy * dy));
		steps = fdiv(len + stride - 1, stride);
		if (steps < 1) steps = 1;
		for (longint i = 0; i <= steps; i++)
			paint_disc(x0 + fdiv(dx * i, steps), y0 + fdiv(dy * i, steps), r);
	endfunction

	function automatic pixel_reply_t apply_request(stroke_req_t q);
		pixel_reply_t rep;
		rep.value = 1'b0;
		rep.oob = 1'b0;
		case (q.op)
			tsr_pkg::OP_STAMP: paint_segment(q);
			tsr_pkg::OP_READ: begin
				if (q.px >= eff_w() || q.py >= eff_h())
					rep.oob = 1'b1;
				else
					rep.value = bmp[int'(q.py) * IMG_PITCH + int'(q.px)];
			end
			tsr_pkg::OP_CLEAR: foreach (bmp[i]) bmp[i] = 1'b0;
			default: ;
		endcase
		return rep;
	endfunction

	task automatic send_item(stroke_req_t q);
		if (burst_left == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
			burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 80) :
				$urandom_range(1, 12);
		end
		in_valid <= 1'b1;
		op <= q.op;
		start_x <= q.sx;
		start_y <= q.sy;
		end_x <= q.ex;
		end_y <= q.ey;
		radius <= q.rad;
		pixel_x <= q.px;
		pixel_y <= q.py;
		do @(posedge clk); while (!in_ready);
		pixel_replies.push_back(apply_request(q));
		burst_left--;
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		burst_left = 0;
		while (pixel_replies.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	task automatic write_reg(logic idx, logic [8:0] value);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		if (idx == tsr_pkg::REG_IMAGE_WIDTH)
			width_reg = {23'd0, value};
		else
			height_reg = {23'd0, value};
		@(posedge clk);
	endtask

	function automatic stroke_req_t make_req(logic [1:0] o, int sx, int sy, int ex, int ey,
			int rad, int px, int py);
		stroke_req_t q;
		q.op = o;
		q.sx = 16'(sx);
		q.sy = 16'(sy);
		q.ex = 16'(ex);
		q.ey = 16'(ey);
		q.rad = 10'(rad);
		q.px = 8'(px);
		q.py = 8'(py);
		return q;
	endfunction

	task automatic read_px(int px, int py);
		send_item(make_req(tsr_pkg::OP_READ, $urandom, $urandom, $urandom, $urandom,
			$urandom, px, py));
	endtask

	function automatic stroke_req_t random_req();
		stroke_req_t q;
		int pick, sx, sy;
		pick = $urandom_range(0, 999);
		q = make_req(tsr_pkg::OP_READ, $urandom, $urandom, $urandom, $urandom, $urandom,
			$urandom, $urandom);
		if (pick < 460) begin
			q.op = tsr_pkg::OP_STAMP;
			sx = $urandom_range(0, 4200) - 64;
			sy = $urandom_range(0, 4200) - 64;
			q.sx = 16'(sx);
			q.sy = 16'(sy);
			q.ex = 16'(sx + $urandom_range(0, 320) - 160);
			q.ey = 16'(sy + $urandom_range(0, 320) - 160);
			q.rad = 10'($urandom_range(0, 56));
			if ($urandom_range(0, 7) == 0) begin
				q.ex = q.sx;
				q.ey = q.sy;
			end
			if (pick < 8) begin
				q.ex = q.sx;
				q.ey = q.sy;
				q.rad = 10'($urandom);
				if (pick < 4) begin
					q.sx = 16'($urandom);
					q.sy = 16'($urandom);
					q.ex = q.sx;
					q.ey = q.sy;
				end
			end else if (pick < 11) begin
				q.ex = 16'($urandom);
				q.ey = 16'($urandom);
				q.rad = 10'($urandom_range(0, 20));
			end
		end else if (pick < 940) begin
			if ($urandom_range(0, 1) == 0) begin
				q.px = 8'(last_x / 16 + $urandom_range(0, 8) - 4);
				q.py = 8'(last_y / 16 + $urandom_range(0, 8) - 4);
			end
		end else if (pick < 970) begin
			q.op = tsr_pkg::OP_CLEAR;
		end else begin
			q.op = OP_UNUSED;
		end
		if (q.op == tsr_pkg::OP_STAMP && q.ex >= 0 && q.ey >= 0) begin
			last_x = q.ex;
			last_y = q.ey;
		end
		return q;
	endfunction

	task automatic test_directed();
		read_px(0, 0);
		read_px(255, 255);
		send_item(make_req(tsr_pkg::OP_STAMP, 88, 88, 88, 88, 0, 0, 0));
		read_px(5, 5);
		send_item(make_req(tsr_pkg::OP_STAMP, 87, 200, 87, 200, 0, 0, 0));
		read_px(5, 12);
		send_item(make_req(tsr_pkg::OP_STAMP, 2048, 2048, 2048, 2048, 1023, 0, 0));
		read_px(128, 128);
		read_px(64, 128);
		read_px(63, 128);
		send_item(make_req(tsr_pkg::OP_STAMP, -32768, -32768, 32767, 32767, 0, 0, 0));
		send_item(make_req(tsr_pkg::OP_STAMP, 32767, -32768, -32768, 32767, 8, 0, 0));
		read_px(200, 55);
		read_px(10, 10);
		send_item(make_req(tsr_pkg::OP_STAMP, 4000, 100, 4150, 300, 40, 0, 0));
		read_px(252, 10);
		send_item(make_req(OP_UNUSED, 100, 100, 100, 100, 200, 6, 6));
		send_item(make_req(tsr_pkg::OP_CLEAR, 0, 0, 0, 0, 0, 0, 0));
		read_px(128, 128);
		read_px(5, 5);
		drain();
	endtask

	task automatic test_config();
		int sizes [6][2] = '{'{1, 1}, '{0, 0}, '{511, 300}, '{100, 37}, '{17, 200},
			'{256, 256}};
		foreach (sizes[k]) begin
			write_reg(tsr_pkg::REG_IMAGE_WIDTH, 9'(sizes[k][0]));
			write_reg(tsr_pkg::REG_IMAGE_HEIGHT, 9'(sizes[k][1]));
			send_item(make_req(tsr_pkg::OP_STAMP, 0, 0, 1700, 700, 24, 0, 0));
			send_item(make_req(tsr_pkg::OP_STAMP, 3000, 3000, 3000, 3000, 300, 0, 0));
			read_px(0, 0);
			read_px(1, 0);
			read_px(0, 1);
			read_px(99, 36);
			read_px(100, 36);
			read_px(16, 37);
			read_px(255, 199);
			read_px(200, 190);
			repeat (12) send_item(random_req());
			drain();
		end
	endtask

	task automatic test_random();
		repeat (948) send_item(random_req());
		drain();
	endtask

	task automatic test_backpressure();
		hold_len = 400;
		repeat (30) read_px($urandom, $urandom);
		drain();
		repeat (40) send_item(random_req());
		drain();
	endtask

	always @(posedge clk) begin
		if (hold_len > 0) begin
			out_ready <= 1'b0;
			hold_len--;
		end else begin
			if (rx_cyc == 0) begin
				rx_mode = $urandom_range(0, 2);
				rx_cyc = $urandom_range(50, 300);
			end
			rx_cyc--;
			case (rx_mode)
				0: out_ready <= 1'b1;
				1: out_ready <= ($urandom_range(0, 9) < 7);
				default: out_ready <= (rx_cyc % 5 != 0);
			endcase
		end
	end

	always @(posedge clk) begin
		pixel_reply_t want;
		if (arst_n && out_valid && out_ready) begin
			if (pixel_replies.size() == 0) begin
				$display("%0t: unexpected result pixel_value %0b out_of_bounds %0b",
					$time, pixel_value, out_of_bounds);
				mismatch_count++;
			end else begin
				want = pixel_replies.pop_front();
				if (pixel_value !== want.value) begin
					$display("%0t: pixel_value expected %0b actual %0b", $time,
						want.value, pixel_value);
					mismatch_count++;
				end
				if (out_of_bounds !== want.oob) begin
					$display("%0t: out_of_bounds expected %0b actual %0b", $time,
						want.oob, out_of_bounds);
					mismatch_count++;
				end
			end
		end
	end

	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
			idle_cycles = 0;
		else
			idle_cycles++;
		if (idle_cycles >= STALL_LIMIT) begin
			$display("%0t: no transaction for %0d cycles", $time, idle_cycles);
			$display("CHECK FAILED");
			$finish;
		end
	end

	initial begin
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_config();
		test_random();
		test_backpressure();
		if (pixel_replies.size() != 0)
			mismatch_count++;
		if (mismatch_count == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule
